// ===== sv/cdad_pkg.sv =====
// ----------------------------------------------------------------------------
// cdad_pkg: shared types, constants and calendar helpers
// Holds the datapath command and status types, field widths and the
// Gregorian month and year length functions used by the date adder.
// ----------------------------------------------------------------------------
package cdad_pkg;

    // Day count width that takes part in the addition.
    localparam int ADD_WIDTH = 16;
    // Width of the days_to_add field on the stream.
    localparam int DAYS_FIELD_W = 16;
    // Bits of the day count actually kept.
    localparam int X_W = (ADD_WIDTH < DAYS_FIELD_W) ? ADD_WIDTH : DAYS_FIELD_W;
    // Running day total must hold a day of year plus the count.
    localparam int ACC_W = ((X_W > 9) ? X_W : 9) + 1;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
    localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;
    localparam logic [DAY_W-1:0]   LAST_DAY  = 5'd31;

    // Reciprocal of 100 scaled by 2^19; exact for every year up to 9999.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_REM,
        OP_CLAMP,
        OP_DOY,
        OP_ADDX,
        OP_YEAR,
        OP_MONTH,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic doy_more;
        logic year_more;
        logic month_more;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_REM,
        S_CLAMP,
        S_DOY,
        S_ADDX,
        S_YEAR,
        S_MONTH,
        S_DONE
    } cdad_state_t;

    // Leap test from the year's low bits, whether it is a whole century,
    // and the century's low bits.
    function automatic logic leap_f(input logic [1:0] y_lo, input logic r_zero,
                                    input logic [1:0] c_lo);
        return r_zero ? (c_lo == 2'd0) : (y_lo == 2'd0);
    endfunction

    function automatic logic [8:0] year_len_f(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [DAY_W-1:0] month_len_f(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/cdad_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdad_ctrl: sequencing controller for the date adder
// Steps the datapath through load, century split, day of year, year
// roll-over and month search, and owns the request handshakes.
// ----------------------------------------------------------------------------
module cdad_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  cdad_pkg::dp_stat_t stat,
    output cdad_pkg::dp_cmd_t  cmd
);
    import cdad_pkg::*;

    cdad_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign s_tready = (state_reg == S_IDLE);

    // State and output-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.op     = OP_DIV;
                state_next = S_REM;
            end
            S_REM: begin
                cmd.op     = OP_REM;
                state_next = S_CLAMP;
            end
            S_CLAMP: begin
                cmd.op     = OP_CLAMP;
                state_next = S_DOY;
            end
            S_DOY: begin
                if (stat.doy_more) begin
                    cmd.op = OP_DOY;
                end else begin
                    state_next = S_ADDX;
                end
            end
            S_ADDX: begin
                cmd.op     = OP_ADDX;
                state_next = S_YEAR;
            end
            S_YEAR: begin
                // The same operation also rewinds the month counter on exit.
                cmd.op = OP_YEAR;
                if (!stat.year_more) begin
                    state_next = S_MONTH;
                end
            end
            S_MONTH: begin
                if (stat.month_more) begin
                    cmd.op = OP_MONTH;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/cdad_dp.sv =====
// ----------------------------------------------------------------------------
// cdad_dp: datapath of the date adder
// Holds the working date, the running day total, the century split of the
// year used for the leap rule, and the output register.
// ----------------------------------------------------------------------------
module cdad_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cdad_pkg::dp_cmd_t           cmd,
    output cdad_pkg::dp_stat_t          stat,
    input  logic [cdad_pkg::DAY_W-1:0]   start_day,
    input  logic [cdad_pkg::MONTH_W-1:0] start_month,
    input  logic [cdad_pkg::YEAR_W-1:0]  start_year,
    input  logic [cdad_pkg::DAYS_FIELD_W-1:0] days_to_add,
    output logic [cdad_pkg::DAY_W-1:0]   end_day,
    output logic [cdad_pkg::MONTH_W-1:0] end_month,
    output logic [cdad_pkg::YEAR_W-1:0]  end_year,
    output logic                        year_overflow
);
    import cdad_pkg::*;

    logic [DAY_W-1:0]   day_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [MONTH_W-1:0] mcnt_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [6:0]         cent_reg;
    logic [6:0]         r100_reg;
    logic [X_W-1:0]     x_reg;
    logic [ACC_W-1:0]   acc_reg;

    logic [DAY_W-1:0]   end_day_reg;
    logic [MONTH_W-1:0] end_month_reg;
    logic [YEAR_W-1:0]  end_year_reg;
    logic               ovf_reg;

    logic [YEAR_W-1:0]  year_clamp;
    logic [MONTH_W-1:0] month_clamp;
    logic [DAY_W-1:0]   day_clamp;
    logic [25:0]        recip_prod;
    logic [YEAR_W-1:0]  cent_x100;
    logic               leap;
    logic [8:0]         ylen;
    logic [DAY_W-1:0]   mlen_cur;
    logic [DAY_W-1:0]   mlen_start;
    logic               past_max;

    // Clamp the incoming year and month into their valid ranges, and raise a zero day to one.
    always_comb begin
        year_clamp = start_year;
        if (start_year == '0) begin
            year_clamp = 14'd1;
        end else if (start_year > MAX_YEAR) begin
            year_clamp = MAX_YEAR;
        end
        month_clamp = start_month;
        if (start_month == '0) begin
            month_clamp = 4'd1;
        end else if (start_month > LAST_MONTH) begin
            month_clamp = LAST_MONTH;
        end
        day_clamp = (start_day == '0) ? 5'd1 : start_day;
    end

    // Century split: quotient by reciprocal, then remainder.
    assign recip_prod = 26'(year_reg) * 26'(RECIP_100);
    assign cent_x100  = YEAR_W'(cent_reg) * YEAR_W'(7'd100);

    // Calendar lengths for the current working year.
    assign leap       = leap_f(year_reg[1:0], (r100_reg == 7'd0), cent_reg[1:0]);
    assign ylen       = year_len_f(leap);
    assign mlen_cur   = month_len_f(mcnt_reg, leap);
    assign mlen_start = month_len_f(month_reg, leap);
    assign past_max   = (year_reg > MAX_YEAR);

    // Status for the controller.
    assign stat.doy_more   = (mcnt_reg < month_reg);
    assign stat.year_more  = (acc_reg > ACC_W'(ylen)) && !past_max;
    assign stat.month_more = (mcnt_reg < LAST_MONTH) && (acc_reg > ACC_W'(mlen_cur));

    // Working registers, driven by the controller's command.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                day_reg   <= day_clamp;
                month_reg <= month_clamp;
                year_reg  <= year_clamp;
                x_reg     <= days_to_add[X_W-1:0];
            end
            OP_DIV: begin
                cent_reg <= recip_prod[RECIP_SHIFT+6:RECIP_SHIFT];
            end
            OP_REM: begin
                r100_reg <= 7'(year_reg - cent_x100);
            end
            OP_CLAMP: begin
                acc_reg  <= ACC_W'((day_reg > mlen_start) ? mlen_start : day_reg);
                mcnt_reg <= 4'd1;
            end
            OP_DOY: begin
                acc_reg  <= acc_reg + ACC_W'(mlen_cur);
                mcnt_reg <= mcnt_reg + 4'd1;
            end
            OP_ADDX: begin
                acc_reg <= acc_reg + ACC_W'(x_reg);
            end
            OP_YEAR: begin
                if (stat.year_more) begin
                    acc_reg  <= acc_reg - ACC_W'(ylen);
                    year_reg <= year_reg + 14'd1;
                    if (r100_reg == 7'd99) begin
                        r100_reg <= 7'd0;
                        cent_reg <= cent_reg + 7'd1;
                    end else begin
                        r100_reg <= r100_reg + 7'd1;
                    end
                end else begin
                    mcnt_reg <= 4'd1;
                end
            end
            OP_MONTH: begin
                acc_reg  <= acc_reg - ACC_W'(mlen_cur);
                mcnt_reg <= mcnt_reg + 4'd1;
            end
            OP_OUT: begin
                if (past_max) begin
                    end_day_reg   <= LAST_DAY;
                    end_month_reg <= LAST_MONTH;
                    end_year_reg  <= MAX_YEAR;
                    ovf_reg       <= 1'b1;
                end else begin
                    end_day_reg   <= acc_reg[DAY_W-1:0];
                    end_month_reg <= mcnt_reg;
                    end_year_reg  <= year_reg;
                    ovf_reg       <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign end_day       = end_day_reg;
    assign end_month     = end_month_reg;
    assign end_year      = end_year_reg;
    assign year_overflow = ovf_reg;

`ifndef SYNTH
    // The century split must reproduce the year exactly.
    a_cent_split: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_REM |=> (r100_reg <= 7'd99) &&
            (year_reg == cent_x100 + YEAR_W'(r100_reg)))
        else $error("century split does not match the year");

    // A year step advances the year by exactly one.
    a_year_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_YEAR && stat.year_more) |=> year_reg == $past(year_reg) + 14'd1)
        else $error("year step did not advance the year by one");

    // A delivered result has a nonzero day, a month from 1 to 12 and a year up to 9999.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_OUT |=> (end_day_reg >= 5'd1) && (end_month_reg >= 4'd1) &&
            (end_month_reg <= LAST_MONTH) && (end_year_reg <= MAX_YEAR))
        else $error("result date out of range");
`endif

endmodule

// ===== sv/calendar_date_add_days_unit.sv =====
// ----------------------------------------------------------------------------
// calendar_date_add_days_unit: Gregorian date plus day count
// Top level joining the sequencing controller and the date datapath.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one request: start date and a day count. The
//   master channel returns the date that many days later with an overflow
//   flag; past year 9999 the result reads 31 December 9999 with the flag set.
//   Out-of-range start fields are clamped to the nearest valid date.
//   One request is worked at a time. The time from acceptance to m_tvalid
//   grows with the months before the start month, the whole years rolled
//   over and the months skipped in the result year; the year roll-over
//   loop subtracts one year length per cycle. s_tready rises together with
//   m_tvalid, so a new request is taken only once the previous result has
//   been loaded into the output register.
//   The result sits in an output register, so s_tready returns as soon as
//   the result is loaded, even while m_tready is low. If a finished result
//   cannot be loaded because the previous one is still stalled, the unit
//   waits with s_tready low until the master side drains.
//   Reset (aresetn low, synchronous) empties the output register and
//   returns the unit to idle.
// ----------------------------------------------------------------------------
module calendar_date_add_days_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: start_day[4:0], start_month[8:5], start_year[22:9],
    //          days_to_add[38:23], zero pad[39]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: end_day[4:0], end_month[8:5], end_year[22:9],
    //          year_overflow[23]
    output logic [23:0] m_tdata
);
    import cdad_pkg::*;

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
    logic               year_overflow;

    // Controller: sequencing and handshakes.
    cdad_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: date arithmetic and output register.
    cdad_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .start_day     (s_tdata[4:0]),
        .start_month   (s_tdata[8:5]),
        .start_year    (s_tdata[22:9]),
        .days_to_add   (s_tdata[38:23]),
        .end_day       (end_day),
        .end_month     (end_month),
        .end_year      (end_year),
        .year_overflow (year_overflow)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {year_overflow, end_year, end_month, end_day};

endmodule

// ===== tb/sv/calendar_date_add_days_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_add_days_unit_tb: self-checking bench for the date adder
// Sends start dates and day counts on the slave channel and predicts each
// resulting date with an independent Gregorian calculation. Results on the
// master channel are checked field by field, in order. Both channels idle
// at random, and one phase holds the master side off long enough to back
// up the unit's input.
// ----------------------------------------------------------------------------
module calendar_date_add_days_unit_tb;
    import cdad_pkg::*;

    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [DAY_W-1:0]        day;
        logic [MONTH_W-1:0]      month;
        logic [YEAR_W-1:0]       year;
        logic [DAYS_FIELD_W-1:0] count;
    } date_req_t;

    typedef struct {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               overflow;
    } date_res_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Dates predicted for accepted requests, oldest first.
    date_res_t end_dates_pending[$];
    int        mismatch_count    = 0;
    bit        src_gaps_on       = 1'b1;
    bit        sink_gaps_on      = 1'b1;
    int        sink_hold_cycles  = 0;

    calendar_date_add_days_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Gregorian calendar prediction
    // ------------------------------------------------------------------
    function automatic bit is_leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned year_length(int unsigned y);
        return is_leap_year(y) ? 366 : 365;
    endfunction

    function automatic int unsigned month_length(int unsigned m, int unsigned y);
        case (m)
            2:           return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic date_res_t predict_end_date(date_req_t r);
        int unsigned d, m, y, x, doy, rem, y2, m2;
        date_res_t   res;
        d = r.day;
        m = r.month;
        y = r.year;
        x = int'(r.count) & ((32'd1 << X_W) - 1);

        // Out-of-range start fields snap to the nearest valid date.
        if (y < 1) y = 1;
        if (y > MAX_YEAR) y = MAX_YEAR;
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        if (d < 1) d = 1;
        if (d > month_length(m, y)) d = month_length(m, y);

        doy = d;
        for (int unsigned k = 1; k < m; k++) doy += month_length(k, y);

        // Stay in the start year or roll whole years forward.
        rem = year_length(y) - doy;
        if (x <= rem) begin
            y2  = y;
            doy = doy + x;
        end else begin
            x  -= rem;
            y2  = y + 1;
            while (x > year_length(y2) && y2 <= MAX_YEAR) begin
                x -= year_length(y2);
                y2++;
            end
            doy = x;
        end

        if (y2 > MAX_YEAR) begin
            res.day      = LAST_DAY;
            res.month    = LAST_MONTH;
            res.year     = MAX_YEAR;
            res.overflow = 1'b1;
        end else begin
            m2 = 1;
            while (m2 < 12 && doy > month_length(m2, y2)) begin
                doy -= month_length(m2, y2);
                m2++;
            end
            res.day      = doy[DAY_W-1:0];
            res.month    = m2[MONTH_W-1:0];
            res.year     = y2[YEAR_W-1:0];
            res.overflow = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_end_date(logic [23:0] word);
        date_res_t got, want;
        got.day      = word[4:0];
        got.month    = word[8:5];
        got.year     = word[22:9];
        got.overflow = word[23];
        if (end_dates_pending.size() == 0) begin
            report_mismatch($sformatf("result %0d-%0d-%0d arrived with no request pending",
                                      got.year, got.month, got.day));
        end else begin
            want = end_dates_pending.pop_front();
            if (got.day !== want.day)
                report_mismatch($sformatf("end_day %0d, expected %0d", got.day, want.day));
            if (got.month !== want.month)
                report_mismatch($sformatf("end_month %0d, expected %0d",
                                          got.month, want.month));
            if (got.year !== want.year)
                report_mismatch($sformatf("end_year %0d, expected %0d", got.year, want.year));
            if (got.overflow !== want.overflow)
                report_mismatch($sformatf("year_overflow %0b, expected %0b",
                                          got.overflow, want.overflow));
        end
    endtask

    // Values are sampled as they stood just before the edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_end_date(m_tdata);
    end

    // ------------------------------------------------------------------
    // Result sink: random stalls per result, plus an optional long hold-off.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = sink_gaps_on ? $urandom_range(0, 10) : 0;
            if (sink_hold_cycles > 0) begin
                gap = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // ------------------------------------------------------------------
    // Request source
    // ------------------------------------------------------------------
    task automatic send_date_request(date_req_t r);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.count, r.year, r.month, r.day};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        end_dates_pending.push_back(predict_end_date(r));
    endtask

    function automatic date_req_t make_request(int d, int m, int y, int n);
        date_req_t r;
        r.day   = d[DAY_W-1:0];
        r.month = m[MONTH_W-1:0];
        r.year  = y[YEAR_W-1:0];
        r.count = n[DAYS_FIELD_W-1:0];
        return r;
    endfunction

    function automatic int draw_day_count();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 400);
            5, 6:          return $urandom_range(0, 2000);
            7, 8:          return $urandom_range(0, 65535);
            default:       return 65535 - $urandom_range(0, 1000);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, leap and century rules, clamping and saturation.
    task automatic test_directed_corners();
        send_date_request(make_request(1, 1, 1, 0));
        send_date_request(make_request(31, 12, 9999, 0));
        send_date_request(make_request(31, 12, 9999, 1));
        send_date_request(make_request(1, 1, 9999, 65535));
        send_date_request(make_request(31, 15, 16383, 65535));
        send_date_request(make_request(0, 0, 0, 0));
        send_date_request(make_request(0, 0, 0, 65535));
        // Results that land on the last day of a year.
        send_date_request(make_request(1, 1, 2023, 364));
        send_date_request(make_request(1, 1, 2024, 365));
        send_date_request(make_request(31, 12, 2023, 366));
        // February in common, leap and century years.
        send_date_request(make_request(28, 2, 2023, 1));
        send_date_request(make_request(28, 2, 2024, 1));
        send_date_request(make_request(29, 2, 1900, 0));
        send_date_request(make_request(29, 2, 2000, 0));
        // Day past the end of its month.
        send_date_request(make_request(31, 4, 2021, 0));
        send_date_request(make_request(30, 2, 2024, 0));
        // Months above December and a year above the maximum.
        send_date_request(make_request(13, 13, 2020, 10));
        send_date_request(make_request(1, 14, 1999, 100));
        send_date_request(make_request(1, 1, 10000, 0));
        // Largest counts near and far from the saturation year.
        send_date_request(make_request(1, 1, 9820, 65535));
        send_date_request(make_request(15, 6, 1600, 65535));
        send_date_request(make_request(1, 1, 1, 65535));
    endtask

    // Well-formed start dates with varied years and counts.
    task automatic test_random_valid_dates(int n_items);
        int d, m, y;
        for (int i = 0; i < n_items; i++) begin
            // Change the idle pattern every hundred requests.
            if (i % 100 == 0) begin
                if (i == 0) begin
                    src_gaps_on  = 1'b1;
                    sink_gaps_on = 1'b1;
                end else if (i == 100) begin
                    src_gaps_on  = 1'b0;
                    sink_gaps_on = 1'b0;
                end else begin
                    src_gaps_on  = ($urandom_range(0, 2) != 0);
                    sink_gaps_on = ($urandom_range(0, 2) != 0);
                end
            end
            case ($urandom_range(0, 9))
                0:       y = $urandom_range(9800, 9999);
                1:       y = $urandom_range(1, 400);
                2:       y = $urandom_range(1, 99) * 100;
                default: y = $urandom_range(1, 9999);
            endcase
            m = $urandom_range(1, 12);
            d = ($urandom_range(0, 3) == 0) ? month_length(m, y)
                                            : $urandom_range(1, month_length(m, y));
            send_date_request(make_request(d, m, y, draw_day_count()));
        end
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    // Unconstrained fields, so every bit and every clamp is reached.
    task automatic test_random_raw_fields(int n_items);
        for (int i = 0; i < n_items; i++) begin
            send_date_request(make_request($urandom_range(0, 31), $urandom_range(0, 15),
                                           $urandom_range(0, 16383),
                                           $urandom_range(0, 65535)));
        end
    endtask

    // The sink holds off while requests keep coming, so the input stalls.
    task automatic test_input_backpressure(int n_items);
        src_gaps_on      = 1'b0;
        sink_hold_cycles = 500;
        for (int i = 0; i < n_items; i++) begin
            send_date_request(make_request($urandom_range(1, 28), $urandom_range(1, 12),
                                           $urandom_range(1, 9999),
                                           $urandom_range(0, 60)));
        end
        src_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : test_sequence
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_random_valid_dates(800);
        test_random_raw_fields(300);
        test_input_backpressure(40);
        s_tvalid <= 1'b0;

        while (end_dates_pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("** calendar_date_add_days_unit: PASSED **");
        end else begin
            $display("** calendar_date_add_days_unit: FAILED **");
        end
        $finish;
    end

    // Hard stop in case the unit hangs.
    initial begin : run_limit
        #15_000_000;
        $display("** calendar_date_add_days_unit: FAILED **");
        $finish;
    end

endmodule
